// ----- rtl/tlhp_pkg.sv -----
// Shared types and constants for the tank level and pump controller.
package tlhp_pkg;

   localparam int unsigned RAW_W = 16;
   localparam int unsigned PCT_W = 7;
   localparam int unsigned NUM_W = 23;
   localparam int unsigned DEN_W = RAW_W + PCT_W - 1;

   localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;
   localparam logic [PCT_W-1:0] PERCENT_EMPTY = 7'd0;

   localparam logic [RAW_W-1:0] FULL_RAW_RESET = 16'd50;
   localparam logic [RAW_W-1:0] EMPTY_RAW_RESET = 16'd200;
   localparam logic [PCT_W-1:0] PUMP_ON_RESET = 7'd40;
   localparam logic [PCT_W-1:0] PUMP_OFF_RESET = 7'd70;
   localparam logic [PCT_W-1:0] LAST_PERCENT_RESET = 7'd25;

   localparam logic [1:0] CSR_FULL_RAW = 2'd0;
   localparam logic [1:0] CSR_EMPTY_RAW = 2'd1;
   localparam logic [1:0] CSR_PUMP_ON = 2'd2;
   localparam logic [1:0] CSR_PUMP_OFF = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PREP = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } scale_state_type;

   typedef enum logic [2:0] {
      T_IDLE   = 3'b001,
      T_BUSY   = 3'b010,
      T_FINISH = 3'b100
   } top_state_type;

   typedef struct packed {
      logic             start;
      logic [RAW_W-1:0] raw;
   } scale_req_type;

   typedef struct packed {
      logic             done;
      logic             usable;
      logic [PCT_W-1:0] percent;
   } scale_sts_type;

endpackage

// ----- rtl/tlhp_scale.sv -----
// Iterative raw-to-percent conversion with a shared shift-subtract divider.
module tlhp_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  tlhp_pkg::scale_req_type         req,
   input  logic [tlhp_pkg::RAW_W-1:0]      full_raw,
   input  logic [tlhp_pkg::RAW_W-1:0]      empty_raw,
   output tlhp_pkg::scale_sts_type         sts
);

   tlhp_pkg::scale_state_type state_ff, state_in;

   logic [tlhp_pkg::RAW_W-1:0] raw_ff, raw_in;
   logic [tlhp_pkg::RAW_W-1:0] mag_d_ff, mag_d_in;
   logic [tlhp_pkg::NUM_W-1:0] rem_ff, rem_in;
   logic [tlhp_pkg::DEN_W-1:0] den_ff, den_in;
   logic [tlhp_pkg::PCT_W-1:0] quo_ff, quo_in;
   logic [2:0]                 count_ff, count_in;
   logic                       usable_ff, usable_in;

   logic [tlhp_pkg::RAW_W:0]   diff_a;
   logic [tlhp_pkg::RAW_W:0]   diff_d;
   logic [tlhp_pkg::RAW_W:0]   neg_a;
   logic [tlhp_pkg::RAW_W:0]   neg_d;
   logic [tlhp_pkg::RAW_W-1:0] mag_a;
   logic [tlhp_pkg::RAW_W-1:0] mag_d;
   logic                       usable;
   logic [tlhp_pkg::NUM_W:0]   trial;

   always_comb begin
      diff_a = {1'b0, empty_raw} - {1'b0, raw_ff};
      diff_d = {1'b0, empty_raw} - {1'b0, full_raw};
      neg_a  = ~diff_a + 17'd1;
      neg_d  = ~diff_d + 17'd1;
      mag_a  = diff_a[tlhp_pkg::RAW_W] ? neg_a[tlhp_pkg::RAW_W-1:0]
                                        : diff_a[tlhp_pkg::RAW_W-1:0];
      mag_d  = diff_d[tlhp_pkg::RAW_W] ? neg_d[tlhp_pkg::RAW_W-1:0]
                                        : diff_d[tlhp_pkg::RAW_W-1:0];
      usable = (full_raw != '0) && (empty_raw != '0) && (full_raw != empty_raw);
      trial  = {1'b0, rem_ff} - {2'b00, den_ff};
   end

   always_comb begin
      state_in  = state_ff;
      raw_in    = raw_ff;
      mag_d_in  = mag_d_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      count_in  = count_ff;
      usable_in = usable_ff;
      unique case (state_ff)
         tlhp_pkg::S_IDLE: begin
            if (req.start) begin
               raw_in   = req.raw;
               state_in = tlhp_pkg::S_PREP;
            end
         end
         tlhp_pkg::S_PREP: begin
            usable_in = usable;
            mag_d_in  = mag_d;
            rem_in    = {7'd0, mag_a};
            state_in  = tlhp_pkg::S_DONE;
            // A quotient of opposite sign truncates to zero or below and
            // clamps to empty; a magnitude at or past the span clamps to full.
            if (!usable) begin
               quo_in = tlhp_pkg::PERCENT_EMPTY;
            end else if (mag_a == '0 ||
                         diff_a[tlhp_pkg::RAW_W] != diff_d[tlhp_pkg::RAW_W]) begin
               quo_in = tlhp_pkg::PERCENT_EMPTY;
            end else if (mag_a >= mag_d) begin
               quo_in = tlhp_pkg::PERCENT_FULL;
            end else begin
               state_in = tlhp_pkg::S_MUL;
            end
         end
         tlhp_pkg::S_MUL: begin
            rem_in   = rem_ff * 23'(tlhp_pkg::PERCENT_FULL);
            den_in   = {mag_d_ff, 6'd0};
            quo_in   = '0;
            count_in = 3'd6;
            state_in = tlhp_pkg::S_DIV;
         end
         tlhp_pkg::S_DIV: begin
            // Dividend is below 128 times the divisor, so seven quotient bits do.
            if (!trial[tlhp_pkg::NUM_W]) begin
               rem_in = trial[tlhp_pkg::NUM_W-1:0];
               quo_in = {quo_ff[tlhp_pkg::PCT_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[tlhp_pkg::PCT_W-2:0], 1'b0};
            end
            den_in   = den_ff >> 1;
            count_in = count_ff - 3'd1;
            if (count_ff == 3'd0) begin
               state_in = tlhp_pkg::S_DONE;
            end
         end
         tlhp_pkg::S_DONE: begin
            state_in = tlhp_pkg::S_IDLE;
         end
         default: begin
            state_in = tlhp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlhp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      raw_ff    <= raw_in;
      mag_d_ff  <= mag_d_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      count_ff  <= count_in;
      usable_ff <= usable_in;
   end

   assign sts.done    = (state_ff == tlhp_pkg::S_DONE);
   assign sts.usable  = usable_ff;
   assign sts.percent = quo_ff;

   a_done_percent_range: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (sts.percent <= tlhp_pkg::PERCENT_FULL))
      else $error("scale result above full");

   a_div_from_mul: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == tlhp_pkg::S_DIV) |-> $past(state_ff == tlhp_pkg::S_MUL))
      else $error("division entered without product");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlhp_pkg::S_PREP) |-> $past(state_ff == tlhp_pkg::S_IDLE))
      else $error("sample taken while busy");

endmodule

// ----- rtl/tank_level_hysteresis_pump.sv -----
// Top level: tank fill percentage from a raw sensor sample, with hysteresis pump control.
//
// Usage:
//   Request channel (req_valid/req_ready, req_raw_sample) takes one raw distance
//   sample. req_ready is high only while the block is idle.
//   Result channel (rsp_valid/rsp_ready) returns one result per request: the fill
//   level in percent, the pump command and a flag that the level was freshly
//   computed from a usable calibration.
//   Configuration port (csr_we, csr_addr, csr_wdata) writes the two calibration
//   points and the pump on/off levels; write only while no request is in flight.
// Timing:
//   When the divider runs, a request passes from acceptance to rsp_valid through
//   setup, multiply by 100, seven shift-subtract steps, hand-off and result load;
//   a clamped result or an unusable calibration skips the multiply and divide.
//   The next request is taken the cycle after the result is loaded, so no new
//   request is taken while one is in flight in the 24-bit subtractor loop.
// Reset:
//   Restores the default calibration, pump off and a held level of 25 percent.
// Stall:
//   A result waiting in the output register does not block the next request;
//   a following result waits in its final state until the register is free.
module tank_level_hysteresis_pump (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tlhp_pkg::RAW_W-1:0]    req_raw_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tlhp_pkg::PCT_W-1:0]    rsp_level_percent,
   output logic                          rsp_pump_cmd,
   output logic                          rsp_level_valid,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_addr,
   input  logic [tlhp_pkg::RAW_W-1:0]    csr_wdata
);

   tlhp_pkg::top_state_type state_ff, state_in;

   logic [tlhp_pkg::RAW_W-1:0] full_raw_ff, full_raw_in;
   logic [tlhp_pkg::RAW_W-1:0] empty_raw_ff, empty_raw_in;
   logic [tlhp_pkg::PCT_W-1:0] pump_on_ff, pump_on_in;
   logic [tlhp_pkg::PCT_W-1:0] pump_off_ff, pump_off_in;
   logic [tlhp_pkg::PCT_W-1:0] last_percent_ff, last_percent_in;
   logic                       pump_ff, pump_in;
   logic [tlhp_pkg::PCT_W-1:0] new_pct_ff, new_pct_in;
   logic                       usable_ff, usable_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tlhp_pkg::PCT_W-1:0] rsp_pct_ff, rsp_pct_in;
   logic                       rsp_pump_ff, rsp_pump_in;
   logic                       rsp_usable_ff, rsp_usable_in;

   tlhp_pkg::scale_req_type scale_req;
   tlhp_pkg::scale_sts_type scale_sts;

   logic                       commit;
   logic [tlhp_pkg::PCT_W-1:0] level;
   logic                       pump_next;

   tlhp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .req       (scale_req),
      .full_raw  (full_raw_ff),
      .empty_raw (empty_raw_ff),
      .sts       (scale_sts)
   );

   assign req_ready       = (state_ff == tlhp_pkg::T_IDLE);
   assign scale_req.start = req_valid && req_ready;
   assign scale_req.raw   = req_raw_sample;

   always_comb begin
      full_raw_in  = full_raw_ff;
      empty_raw_in = empty_raw_ff;
      pump_on_in   = pump_on_ff;
      pump_off_in  = pump_off_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tlhp_pkg::CSR_FULL_RAW:  full_raw_in  = csr_wdata;
            tlhp_pkg::CSR_EMPTY_RAW: empty_raw_in = csr_wdata;
            tlhp_pkg::CSR_PUMP_ON:   pump_on_in   = csr_wdata[tlhp_pkg::PCT_W-1:0];
            tlhp_pkg::CSR_PUMP_OFF:  pump_off_in  = csr_wdata[tlhp_pkg::PCT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      commit = (state_ff == tlhp_pkg::T_FINISH) && (!rsp_valid_ff || rsp_ready);
      level  = usable_ff ? new_pct_ff : last_percent_ff;
      // The on check wins over the off check when the two levels overlap.
      if (level < pump_on_ff) begin
         pump_next = 1'b1;
      end else if (level >= pump_off_ff) begin
         pump_next = 1'b0;
      end else begin
         pump_next = pump_ff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      new_pct_in      = new_pct_ff;
      usable_in       = usable_ff;
      last_percent_in = last_percent_ff;
      pump_in         = pump_ff;
      rsp_pct_in      = rsp_pct_ff;
      rsp_pump_in     = rsp_pump_ff;
      rsp_usable_in   = rsp_usable_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         tlhp_pkg::T_IDLE: begin
            if (scale_req.start) begin
               state_in = tlhp_pkg::T_BUSY;
            end
         end
         tlhp_pkg::T_BUSY: begin
            if (scale_sts.done) begin
               new_pct_in = scale_sts.percent;
               usable_in  = scale_sts.usable;
               state_in   = tlhp_pkg::T_FINISH;
            end
         end
         tlhp_pkg::T_FINISH: begin
            if (commit) begin
               last_percent_in = level;
               pump_in         = pump_next;
               rsp_pct_in      = level;
               rsp_pump_in     = pump_next;
               rsp_usable_in   = usable_ff;
               rsp_valid_in    = 1'b1;
               state_in        = tlhp_pkg::T_IDLE;
            end
         end
         default: begin
            state_in = tlhp_pkg::T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tlhp_pkg::T_IDLE;
         full_raw_ff     <= tlhp_pkg::FULL_RAW_RESET;
         empty_raw_ff    <= tlhp_pkg::EMPTY_RAW_RESET;
         pump_on_ff      <= tlhp_pkg::PUMP_ON_RESET;
         pump_off_ff     <= tlhp_pkg::PUMP_OFF_RESET;
         last_percent_ff <= tlhp_pkg::LAST_PERCENT_RESET;
         pump_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         full_raw_ff     <= full_raw_in;
         empty_raw_ff    <= empty_raw_in;
         pump_on_ff      <= pump_on_in;
         pump_off_ff     <= pump_off_in;
         last_percent_ff <= last_percent_in;
         pump_ff         <= pump_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      new_pct_ff    <= new_pct_in;
      usable_ff     <= usable_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_pump_ff   <= rsp_pump_in;
      rsp_usable_ff <= rsp_usable_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_percent = rsp_pct_ff;
   assign rsp_pump_cmd      = rsp_pump_ff;
   assign rsp_level_valid   = rsp_usable_ff;

   a_done_only_busy: assert property (@(posedge clock) disable iff (reset)
      scale_sts.done |-> (state_ff == tlhp_pkg::T_BUSY))
      else $error("scale finished with no request in flight");

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   a_hold_unusable: assert property (@(posedge clock) disable iff (reset)
      (commit && !usable_ff) |=> (rsp_level_percent == $past(last_percent_ff)))
      else $error("held level changed without a usable calibration");

   a_pump_on_below: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_pump_cmd == pump_ff) && (rsp_level_percent == last_percent_ff))
      else $error("result does not match controller state");

endmodule
